// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define TCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tcc_pkg.sv =====
// Shared types, widths and helper functions of the triangle/circle classifier.
// No dependencies.
package tcc_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = COORD_W - 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W + 2;
  localparam int HALF_W  = SQ_W / 2;
  localparam int PART_W  = 2 * HALF_W + 2;
  localparam int PROD_W  = 2 * SQ_W;
  localparam int QUO_W   = SQ_W;
  localparam int OUT_W   = 63;
  localparam logic [OUT_W-1:0] SAT_MAX = {OUT_W{1'b1}};

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    REL_ALL_IN    = 3'd0,
    REL_VERTEX_IN = 3'd1,
    REL_CENTER_IN = 3'd2,
    REL_EDGE0     = 3'd3,
    REL_EDGE1     = 3'd4,
    REL_EDGE2     = 3'd5,
    REL_NONE      = 3'd6
  } rel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [COORD_W-1:0] vertex_a_z;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [COORD_W-1:0] vertex_b_z;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic signed [COORD_W-1:0] vertex_c_z;
  } tri_item_t;

  typedef struct packed {
    logic [2:0]       relation;
    logic [OUT_W-1:0] longest_edge_sq;
    logic [OUT_W-1:0] distance_sq;
    logic             distance_valid;
  } res_item_t;

  // Circle configuration as seen by the datapath.
  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]          radius;
  } circle_t;

  // Products and dot terms handed from the geometry front end to the classifier.
  typedef struct packed {
    logic [2:0]               vin;
    logic signed [SQ_W-1:0]   q0, q1, q2;
    logic signed [SQ_W-1:0]   d00, d11, d22, d02, d12, k2;
    logic signed [PROD_W-1:0] den_a, den_b, n0_a, n0_b, n1_a, n1_b;
    logic signed [PROD_W-1:0] e0_d00, e0_d11, e1_d22, kk0, kk1, kk2;
  } geo_t;

  // The four partial products of a wide product, split at HALF_W bits.
  typedef struct packed {
    logic signed [PART_W-1:0] ll, lh, hl, hh;
  } part_t;

  // Work handed to the divider: dist = sq - floor(kk / dd) when use_div is set.
  typedef struct packed {
    logic [2:0]        relation;
    logic [OUT_W-1:0]  longest;
    logic [SQ_W-1:0]   sq;
    logic [PROD_W-1:0] kk;
    logic [SQ_W-1:0]   dd;
    logic              use_div;
    logic              dvalid;
  } div_job_t;

  function automatic logic signed [SQ_W-1:0] dot3(
    input logic signed [DIFF_W-1:0] p0, p1, p2, r0, r1, r2
  );
    logic signed [SQ_W-1:0] x, y, z;
    x = SQ_W'(p0) * SQ_W'(r0);
    y = SQ_W'(p1) * SQ_W'(r1);
    z = SQ_W'(p2) * SQ_W'(r2);
    return x + y + z;
  endfunction

  // The low halves are unsigned, the high halves carry the sign.
  function automatic part_t mul_part(input logic signed [SQ_W-1:0] a, b);
    logic signed [HALF_W:0]   al, bl;
    logic signed [HALF_W-1:0] ah, bh;
    part_t                    p;
    al   = {1'b0, a[HALF_W-1:0]};
    bl   = {1'b0, b[HALF_W-1:0]};
    ah   = a[SQ_W-1:HALF_W];
    bh   = b[SQ_W-1:HALF_W];
    p.ll = PART_W'(al) * PART_W'(bl);
    p.lh = PART_W'(al) * PART_W'(bh);
    p.hl = PART_W'(ah) * PART_W'(bl);
    p.hh = PART_W'(ah) * PART_W'(bh);
    return p;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_join(input part_t p);
    logic signed [PROD_W-1:0] mid;
    mid = PROD_W'(p.lh) + PROD_W'(p.hl);
    return (PROD_W'(p.hh) <<< SQ_W) + (mid <<< HALF_W) + PROD_W'(p.ll);
  endfunction

  // Saturate a non-negative value to the 63-bit result range.
  function automatic logic [OUT_W-1:0] sat63(input logic [SQ_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (|v[SQ_W-1:OUT_W]) begin
      r = SAT_MAX;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/tcc_if.sv =====
// Valid/ready channel interfaces for triangles in and classifications out.
// Depends on tcc_pkg for the payload types.
interface tcc_tri_if import tcc_pkg::*; ();
  logic      valid;
  logic      ready;
  tri_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcc_res_if import tcc_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/tcc_front.sv =====
// Geometry front end: vertex differences, dot products, partial products and
// then the summed pairwise products, in four register stages. Depends on tcc_pkg.
module tcc_front import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  tri_item_t in_item,
  input  circle_t   circle,
  output logic      geo_valid,
  output geo_t      geo
);

  typedef struct packed {
    logic [2:0]             vin;
    logic signed [SQ_W-1:0] q0, q1, q2, d00, d11, d22, d02, d12, k2;
  } dots_t;

  // Stage 1: differences from vertex a/b/c, squared radius.
  logic                     s1_valid;
  logic signed [DIFF_W-1:0] c0 [3];
  logic signed [DIFF_W-1:0] c1 [3];
  logic signed [DIFF_W-1:0] c2 [3];
  logic signed [DIFF_W-1:0] v0 [3];
  logic signed [DIFF_W-1:0] v1 [3];
  logic signed [DIFF_W-1:0] v2 [3];
  logic signed [SQ_W-1:0]   s1_r2;

  // Stage 2: dot products.
  logic                   s2_valid;
  logic signed [SQ_W-1:0] r2, q0, q1, q2, d00, d01, d02, d11, d12, d22, k2;

  // Stage 3: dot products carried on, partial products of the pairwise terms.
  logic  s3_valid;
  dots_t s3;
  part_t p_den_a, p_den_b, p_n0_a, p_n0_b, p_n1_a, p_n1_b;
  part_t p_e0_d00, p_e0_d11, p_e1_d22, p_kk0, p_kk1, p_kk2;

  logic signed [DIFF_W-1:0] cen [3];
  logic signed [DIFF_W-1:0] va [3];
  logic signed [DIFF_W-1:0] vb [3];
  logic signed [DIFF_W-1:0] vc [3];
  logic signed [SQ_W-1:0]   e0, e1;

  always_comb begin
    cen[0] = DIFF_W'(circle.center_x);
    cen[1] = DIFF_W'(circle.center_y);
    cen[2] = DIFF_W'(circle.center_z);
    va[0]  = DIFF_W'(in_item.vertex_a_x);
    va[1]  = DIFF_W'(in_item.vertex_a_y);
    va[2]  = DIFF_W'(in_item.vertex_a_z);
    vb[0]  = DIFF_W'(in_item.vertex_b_x);
    vb[1]  = DIFF_W'(in_item.vertex_b_y);
    vb[2]  = DIFF_W'(in_item.vertex_b_z);
    vc[0]  = DIFF_W'(in_item.vertex_c_x);
    vc[1]  = DIFF_W'(in_item.vertex_c_y);
    vc[2]  = DIFF_W'(in_item.vertex_c_z);
  end

  assign e0 = q0 - r2;
  assign e1 = q1 - r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      geo_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      geo_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c0[k] <= cen[k] - va[k];
        c1[k] <= cen[k] - vb[k];
        c2[k] <= cen[k] - vc[k];
        v0[k] <= vb[k] - va[k];
        v1[k] <= vc[k] - va[k];
        v2[k] <= vc[k] - vb[k];
      end
      s1_r2 <= SQ_W'({1'b0, circle.radius}) * SQ_W'({1'b0, circle.radius});

      r2  <= s1_r2;
      q0  <= dot3(c0[0], c0[1], c0[2], c0[0], c0[1], c0[2]);
      q1  <= dot3(c1[0], c1[1], c1[2], c1[0], c1[1], c1[2]);
      q2  <= dot3(c2[0], c2[1], c2[2], c2[0], c2[1], c2[2]);
      d00 <= dot3(v0[0], v0[1], v0[2], v0[0], v0[1], v0[2]);
      d01 <= dot3(v0[0], v0[1], v0[2], v1[0], v1[1], v1[2]);
      d02 <= dot3(v0[0], v0[1], v0[2], c0[0], c0[1], c0[2]);
      d11 <= dot3(v1[0], v1[1], v1[2], v1[0], v1[1], v1[2]);
      d12 <= dot3(v1[0], v1[1], v1[2], c0[0], c0[1], c0[2]);
      d22 <= dot3(v2[0], v2[1], v2[2], v2[0], v2[1], v2[2]);
      k2  <= dot3(c1[0], c1[1], c1[2], v2[0], v2[1], v2[2]);

      s3.vin   <= {q2 <= r2, q1 <= r2, q0 <= r2};
      s3.q0    <= q0;
      s3.q1    <= q1;
      s3.q2    <= q2;
      s3.d00   <= d00;
      s3.d11   <= d11;
      s3.d22   <= d22;
      s3.d02   <= d02;
      s3.d12   <= d12;
      s3.k2    <= k2;
      p_den_a  <= mul_part(d00, d11);
      p_den_b  <= mul_part(d01, d01);
      p_n0_a   <= mul_part(d02, d11);
      p_n0_b   <= mul_part(d12, d01);
      p_n1_a   <= mul_part(d12, d00);
      p_n1_b   <= mul_part(d02, d01);
      p_e0_d00 <= mul_part(e0, d00);
      p_e0_d11 <= mul_part(e0, d11);
      p_e1_d22 <= mul_part(e1, d22);
      p_kk0    <= mul_part(d02, d02);
      p_kk1    <= mul_part(d12, d12);
      p_kk2    <= mul_part(k2, k2);

      geo.vin    <= s3.vin;
      geo.q0     <= s3.q0;
      geo.q1     <= s3.q1;
      geo.q2     <= s3.q2;
      geo.d00    <= s3.d00;
      geo.d11    <= s3.d11;
      geo.d22    <= s3.d22;
      geo.d02    <= s3.d02;
      geo.d12    <= s3.d12;
      geo.k2     <= s3.k2;
      geo.den_a  <= mul_join(p_den_a);
      geo.den_b  <= mul_join(p_den_b);
      geo.n0_a   <= mul_join(p_n0_a);
      geo.n0_b   <= mul_join(p_n0_b);
      geo.n1_a   <= mul_join(p_n1_a);
      geo.n1_b   <= mul_join(p_n1_b);
      geo.e0_d00 <= mul_join(p_e0_d00);
      geo.e0_d11 <= mul_join(p_e0_d11);
      geo.e1_d22 <= mul_join(p_e1_d22);
      geo.kk0    <= mul_join(p_kk0);
      geo.kk1    <= mul_join(p_kk1);
      geo.kk2    <= mul_join(p_kk2);
    end
  end

endmodule

// ===== design/tcc_classify.sv =====
// Classification stage: barycentric and edge tests, region choice for the
// distance. One register stage. Depends on tcc_pkg.
module tcc_classify import tcc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     geo_valid,
  input  geo_t     geo,
  output logic     job_valid,
  output div_job_t job
);

  logic signed [PROD_W-1:0] den, n0, n1, nsum;
  logic                     center_in, x0, x1, x2;
  logic [SQ_W-1:0]          lmax;
  div_job_t                 job_next;

  always_comb begin
    den  = geo.den_a - geo.den_b;
    n0   = geo.n0_a - geo.n0_b;
    n1   = geo.n1_a - geo.n1_b;
    nsum = n0 + n1;
    center_in = (den != '0) && !n0[PROD_W-1] && !n1[PROD_W-1] && (nsum <= den);
    x0 = !geo.d02[SQ_W-1] && (geo.d02 <= geo.d00) && (geo.e0_d00 <= geo.kk0);
    x1 = !geo.d12[SQ_W-1] && (geo.d12 <= geo.d11) && (geo.e0_d11 <= geo.kk1);
    x2 = !geo.k2[SQ_W-1] && (geo.k2 <= geo.d22) && (geo.e1_d22 <= geo.kk2);

    lmax = geo.d00;
    if (geo.d11 > $signed(lmax)) begin
      lmax = geo.d11;
    end
    if (geo.d22 > $signed(lmax)) begin
      lmax = geo.d22;
    end

    job_next = '0;
    if (geo.vin == 3'b111) begin
      job_next.relation = REL_ALL_IN;
    end else if (geo.vin != 3'b000) begin
      job_next.relation = REL_VERTEX_IN;
    end else if (center_in) begin
      job_next.relation = REL_CENTER_IN;
    end else if (x0) begin
      job_next.relation = REL_EDGE0;
    end else if (x1) begin
      job_next.relation = REL_EDGE1;
    end else if (x2) begin
      job_next.relation = REL_EDGE2;
    end else begin
      job_next.relation = REL_NONE;
      job_next.longest  = sat63(lmax);
      job_next.dvalid   = 1'b1;
      // Edge regions first, then the vertex regions.
      if (!geo.d02[SQ_W-1] && geo.d02 <= geo.d00 && n1[PROD_W-1]) begin
        job_next.sq      = geo.q0;
        job_next.kk      = geo.kk0;
        job_next.dd      = geo.d00;
        job_next.use_div = (geo.d00 != '0);
      end else if (!geo.d12[SQ_W-1] && geo.d12 <= geo.d11 && n0[PROD_W-1]) begin
        job_next.sq      = geo.q0;
        job_next.kk      = geo.kk1;
        job_next.dd      = geo.d11;
        job_next.use_div = (geo.d11 != '0);
      end else if (!geo.k2[SQ_W-1] && geo.k2 <= geo.d22 && nsum > den) begin
        job_next.sq      = geo.q1;
        job_next.kk      = geo.kk2;
        job_next.dd      = geo.d22;
        job_next.use_div = (geo.d22 != '0);
      end else if (geo.d02[SQ_W-1] && geo.d12[SQ_W-1]) begin
        job_next.sq = geo.q0;
      end else if (!geo.d02[SQ_W-1] && geo.d02 != '0 && geo.k2[SQ_W-1]) begin
        job_next.sq = geo.q1;
      end else if (!geo.d12[SQ_W-1] && geo.d12 != '0 && !geo.k2[SQ_W-1]
                   && geo.k2 != '0) begin
        job_next.sq = geo.q2;
      end else begin
        job_next.dvalid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (en) begin
      job_valid <= geo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job <= job_next;
    end
  end

endmodule

// ===== design/tcc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, followed by the
// result register that forms distance_sq. Depends on tcc_pkg.
module tcc_div import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      job_valid,
  input  div_job_t  job,
  output logic      res_valid,
  output res_item_t res
);

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    div_job_t          job;
  } dstage_t;

  dstage_t st [QUO_W+1];
  logic    vld [QUO_W+1];

  assign vld[0]     = job_valid;
  assign st[0].rem  = job.kk;
  assign st[0].quo  = '0;
  assign st[0].job  = job;

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int BIT = QUO_W - 1 - i;
    logic [PROD_W-1:0] dsh;
    logic              take;

    // PROD_W is twice SQ_W, so the shifted divisor always fits and no bits are lost.
    assign dsh  = PROD_W'(st[i].job.dd) << BIT;
    assign take = st[i].job.use_div && (st[i].rem >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1].job <= st[i].job;
        st[i+1].rem <= take ? st[i].rem - dsh : st[i].rem;
        st[i+1].quo <= st[i].quo | (QUO_W'(take) << BIT);
      end
    end
  end

  logic [SQ_W-1:0] sep_sq;
  assign sep_sq = st[QUO_W].job.sq - st[QUO_W].quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.relation        <= st[QUO_W].job.relation;
      res.longest_edge_sq <= st[QUO_W].job.longest;
      res.distance_sq     <= st[QUO_W].job.dvalid ? sat63(sep_sq) : '0;
      res.distance_valid  <= st[QUO_W].job.dvalid;
    end
  end

endmodule

// ===== design/triangle_circle_classifier.sv =====
// Triangle/circle classifier top level: circle registers and the pipeline.
// The path from an accepted triangle to its result holds 4 geometry stages,
// 1 classify stage, 68 divider stages for the edge distance and 1 result register.
// Throughput: one triangle per cycle; the whole pipeline holds when a result waits.
// Reset (synchronous, rst high) clears the circle to center 0, radius 0 and
// empties the pipeline.
module triangle_circle_classifier import tcc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  tcc_tri_if.sink        tri_in,
  tcc_res_if.source      res_out,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  circle_t  circle;
  logic     en;
  logic     geo_valid, job_valid, res_valid;
  geo_t     geo;
  div_job_t job;
  res_item_t res;

  // The pipeline advances unless a finished result is waiting on the output.
  assign en           = !res_valid || res_out.ready;
  assign tri_in.ready = en;
  assign res_out.valid = res_valid;
  assign res_out.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: circle.center_x <= cfg_data;
        REG_CENTER_Y: circle.center_y <= cfg_data;
        REG_CENTER_Z: circle.center_z <= cfg_data;
        REG_RADIUS:   circle.radius   <= cfg_data[RAD_W-1:0];
        default:      circle          <= circle;
      endcase
    end
  end

  tcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tri_in.valid),
    .in_item   (tri_in.data),
    .circle    (circle),
    .geo_valid (geo_valid),
    .geo       (geo)
  );

  tcc_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .geo_valid (geo_valid),
    .geo       (geo),
    .job_valid (job_valid),
    .job       (job)
  );

  tcc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .job_valid (job_valid),
    .job       (job),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

// ===== design/tcc_checker.sv =====
// Port-level checks of the classifier's result channel, bound to the top level.
// Depends on tcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcc_checker import tcc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input res_item_t out_data
);

  `TCC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `TCC_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `TCC_ASSERT(a_stall_blocks_in, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")
  `TCC_ASSERT(a_dist_only_none, out_valid && out_data.distance_valid |-> out_data.relation == REL_NONE, "distance on an intersecting result")
  `TCC_ASSERT(a_hit_zero, out_valid && out_data.relation != REL_NONE |-> out_data.longest_edge_sq == '0 && out_data.distance_sq == '0, "nonzero sizes on an intersecting result")

endmodule

bind triangle_circle_classifier tcc_checker u_tcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (tri_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_data  (res_out.data)
);

// ===== sim/tb.sv =====
// Self-checking testbench for triangle_circle_classifier: random and directed triangles
// against several circle settings, checked against an exact wide-integer predictor.
// Depends on tcc_pkg and the tcc_tri_if / tcc_res_if channel interfaces.
module tb import tcc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [159:0] wide_t;

  localparam logic signed [31:0] UNIT = 32'sd65536;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [COORD_W-1:0] cfg_data;

  tcc_tri_if tri_if ();
  tcc_res_if res_if ();

  triangle_circle_classifier u_dut (
    .clk(clk), .rst(rst), .tri_in(tri_if), .res_out(res_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Circle as the predictor sees it.
  logic signed [31:0] circ_x, circ_y, circ_z;
  logic [30:0] circ_r;

  tri_item_t triangle_q[$];
  res_item_t class_q[$];
  int errors;
  int rel_seen[7];
  int phase_no;
  logic hold_long;

  initial clk = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic wide_t inner(input wide_t p0, p1, p2, r0, r1, r2);
    return p0 * r0 + p1 * r1 + p2 * r2;
  endfunction

  function automatic logic edge_hit(input wide_t k, d, e);
    return k >= 0 && k <= d && e * d <= k * k;
  endfunction

  function automatic wide_t seg_dist(input wide_t sq, k, d);
    wide_t dd;
    if (d == 0) begin
      dd = sq;
    end else begin
      dd = sq - (k * k) / d;
    end
    return dd;
  endfunction

  function automatic logic [62:0] clamp63(input wide_t v);
    logic [62:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > wide_t'(64'h7FFF_FFFF_FFFF_FFFF)) begin
      r = SAT_MAX;
    end else begin
      r = v[62:0];
    end
    return r;
  endfunction

  function automatic res_item_t classify(input tri_item_t t);
    wide_t cen[3], a[3], b[3], c[3], c0[3], c1[3], c2[3], v0[3], v1[3], v2[3];
    wide_t rr, r2, q0, q1, q2, d00, d01, d02, d11, d12, d22, k2, den, n0, n1, nsum;
    wide_t sep, lng;
    int cnt;
    logic ok;
    res_item_t res;
    cen[0] = circ_x; cen[1] = circ_y; cen[2] = circ_z;
    a[0] = t.vertex_a_x; a[1] = t.vertex_a_y; a[2] = t.vertex_a_z;
    b[0] = t.vertex_b_x; b[1] = t.vertex_b_y; b[2] = t.vertex_b_z;
    c[0] = t.vertex_c_x; c[1] = t.vertex_c_y; c[2] = t.vertex_c_z;
    for (int i = 0; i < 3; i++) begin
      c0[i] = cen[i] - a[i]; c1[i] = cen[i] - b[i]; c2[i] = cen[i] - c[i];
      v0[i] = b[i] - a[i]; v1[i] = c[i] - a[i]; v2[i] = c[i] - b[i];
    end
    res = '0;
    rr = {129'b0, circ_r};
    r2 = rr * rr;
    q0 = inner(c0[0], c0[1], c0[2], c0[0], c0[1], c0[2]);
    q1 = inner(c1[0], c1[1], c1[2], c1[0], c1[1], c1[2]);
    q2 = inner(c2[0], c2[1], c2[2], c2[0], c2[1], c2[2]);
    cnt = int'(q0 <= r2) + int'(q1 <= r2) + int'(q2 <= r2);
    if (cnt > 0) begin
      res.relation = (cnt == 3) ? REL_ALL_IN : REL_VERTEX_IN;
      return res;
    end
    d00 = inner(v0[0], v0[1], v0[2], v0[0], v0[1], v0[2]);
    d01 = inner(v0[0], v0[1], v0[2], v1[0], v1[1], v1[2]);
    d02 = inner(v0[0], v0[1], v0[2], c0[0], c0[1], c0[2]);
    d11 = inner(v1[0], v1[1], v1[2], v1[0], v1[1], v1[2]);
    d12 = inner(v1[0], v1[1], v1[2], c0[0], c0[1], c0[2]);
    den = d00 * d11 - d01 * d01;
    n0 = d02 * d11 - d12 * d01;
    n1 = d12 * d00 - d02 * d01;
    nsum = n0 + n1;
    if (den != 0 && n0 >= 0 && n1 >= 0 && nsum <= den) begin
      res.relation = REL_CENTER_IN;
      return res;
    end
    d22 = inner(v2[0], v2[1], v2[2], v2[0], v2[1], v2[2]);
    k2 = inner(c1[0], c1[1], c1[2], v2[0], v2[1], v2[2]);
    if (edge_hit(d02, d00, q0 - r2)) begin
      res.relation = REL_EDGE0;
      return res;
    end
    if (edge_hit(d12, d11, q0 - r2)) begin
      res.relation = REL_EDGE1;
      return res;
    end
    if (edge_hit(k2, d22, q1 - r2)) begin
      res.relation = REL_EDGE2;
      return res;
    end
    ok = 1'b1;
    sep = 0;
    if (d02 >= 0 && d02 <= d00 && n1 < 0) begin
      sep = seg_dist(q0, d02, d00);
    end else if (d12 >= 0 && d12 <= d11 && n0 < 0) begin
      sep = seg_dist(q0, d12, d11);
    end else if (k2 >= 0 && k2 <= d22 && nsum > den) begin
      sep = seg_dist(q1, k2, d22);
    end else if (d02 < 0 && d12 < 0) begin
      sep = q0;
    end else if (d02 > 0 && k2 < 0) begin
      sep = q1;
    end else if (d12 > 0 && k2 > 0) begin
      sep = q2;
    end else begin
      ok = 1'b0;
    end
    lng = d00;
    if (d11 > lng) lng = d11;
    if (d22 > lng) lng = d22;
    res.relation = REL_NONE;
    res.longest_edge_sq = clamp63(lng);
    res.distance_sq = ok ? clamp63(sep) : '0;
    res.distance_valid = ok;
    return res;
  endfunction

  task automatic report(input string what, input logic [62:0] got, input logic [62:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Sender side: the handshake of the last edge decides whether the next beat may go.
  logic tri_took, res_took, send_fast, recv_fast;
  int send_gap, recv_stall;

  always @(posedge clk) begin
    tri_took <= tri_if.valid && tri_if.ready;
    res_took <= res_if.valid && res_if.ready;
    if (!rst && tri_if.valid && tri_if.ready) begin
      class_q = {class_q, classify(tri_if.data)};
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      tri_if.valid <= 1'b0;
      send_gap <= 0;
      send_fast <= 1'b0;
    end else if (!tri_if.valid || tri_took) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        tri_if.valid <= 1'b0;
      end else if (triangle_q.size() > 0) begin
        tri_if.data <= triangle_q.pop_front();
        tri_if.valid <= 1'b1;
        if ($urandom_range(0, 47) == 0) send_fast <= !send_fast;
        send_gap <= send_fast ? 0 : $urandom_range(0, 12);
      end else begin
        tri_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int n;
    if (rst) begin
      res_if.ready <= 1'b0;
      recv_stall <= 0;
      recv_fast <= 1'b0;
    end else if (hold_long) begin
      res_if.ready <= 1'b0;
    end else if (res_took) begin
      if ($urandom_range(0, 47) == 0) recv_fast <= !recv_fast;
      n = recv_fast ? 0 : $urandom_range(0, 12);
      recv_stall <= n;
      res_if.ready <= (n == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      res_if.ready <= (recv_stall == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (class_q.size() == 0) begin
        report("unexpected beat", 63'(res_if.data.relation), 63'h0);
      end else begin
        want = class_q.pop_front();
        if (res_if.data.relation <= 3'd6) rel_seen[res_if.data.relation]++;
        if (res_if.data.relation !== want.relation)
          report("relation", 63'(res_if.data.relation), 63'(want.relation));
        if (res_if.data.longest_edge_sq !== want.longest_edge_sq)
          report("longest_edge_sq", res_if.data.longest_edge_sq, want.longest_edge_sq);
        if (res_if.data.distance_sq !== want.distance_sq)
          report("distance_sq", res_if.data.distance_sq, want.distance_sq);
        if (res_if.data.distance_valid !== want.distance_valid)
          report("distance_valid", 63'(res_if.data.distance_valid),
                 63'(want.distance_valid));
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering triangles.
  initial begin
    hold_long = 1'b0;
    wait (phase_no == 3);
    repeat (40) @(posedge clk);
    hold_long <= 1'b1;
    repeat (400) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin
    #6_000_000;
    $display("timeout waiting for results");
    $display("tb: failure");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_X: circ_x = v;
      REG_CENTER_Y: circ_y = v;
      REG_CENTER_Z: circ_z = v;
      default: circ_r = v[30:0];
    endcase
  endtask

  task automatic set_circle(input logic [31:0] x, y, z, r);
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_RADIUS, r);
  endtask

  task automatic add_tri(input logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    tri_item_t t;
    t = {ax, ay, az, bx, by, bz, cx, cy, cz};
    triangle_q = {triangle_q, t};
  endtask

  function automatic logic [31:0] near_coord(input logic [31:0] base, input int scale);
    logic signed [31:0] off;
    off = $signed($urandom) >>> (32 - scale);
    return base + off;
  endfunction

  task automatic add_random_tri();
    tri_item_t t;
    int mode, sc;
    mode = $urandom_range(0, 9);
    sc = $urandom_range(4, 31);
    if (mode == 0) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else begin
      t.vertex_a_x = near_coord(circ_x, sc);
      t.vertex_a_y = near_coord(circ_y, sc);
      t.vertex_a_z = near_coord(circ_z, $urandom_range(1, sc));
      t.vertex_b_x = near_coord(circ_x, sc);
      t.vertex_b_y = near_coord(circ_y, sc);
      t.vertex_b_z = near_coord(circ_z, $urandom_range(1, sc));
      t.vertex_c_x = near_coord(circ_x, sc);
      t.vertex_c_y = near_coord(circ_y, sc);
      t.vertex_c_z = near_coord(circ_z, $urandom_range(1, sc));
      if (mode == 1) begin
        // Collinear or repeated vertices make the triangle degenerate.
        t.vertex_c_x = t.vertex_b_x + (t.vertex_b_x - t.vertex_a_x);
        t.vertex_c_y = t.vertex_b_y + (t.vertex_b_y - t.vertex_a_y);
        t.vertex_c_z = t.vertex_b_z + (t.vertex_b_z - t.vertex_a_z);
      end else if (mode == 2) begin
        t.vertex_b_x = t.vertex_a_x;
        t.vertex_b_y = t.vertex_a_y;
        t.vertex_b_z = t.vertex_a_z;
      end
    end
    triangle_q = {triangle_q, t};
  endtask

  task automatic drain();
    wait (triangle_q.size() == 0 && !tri_if.valid && class_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int rs;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    tri_if.valid = 1'b0;
    tri_if.data = '0;
    res_if.ready = 1'b0;
    circ_x = 0; circ_y = 0; circ_z = 0; circ_r = 0;
    errors = 0;
    phase_no = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed triangles around a unit circle at the origin.
    set_circle(32'd0, 32'd0, 32'd0, UNIT);
    add_tri(0, 0, 0, UNIT / 2, 0, 0, 0, UNIT / 2, 0);
    add_tri(0, 0, 0, 10 * UNIT, 0, 0, 0, 10 * UNIT, 0);
    add_tri(UNIT, 0, 0, 5 * UNIT, 5 * UNIT, 0, 5 * UNIT, -5 * UNIT, 0);
    add_tri(-5 * UNIT, -5 * UNIT, 0, 5 * UNIT, -5 * UNIT, 0, 0, 5 * UNIT, 0);
    add_tri(-5 * UNIT, -5 * UNIT, 5 * UNIT, 5 * UNIT, -5 * UNIT, 5 * UNIT,
            0, 5 * UNIT, 5 * UNIT);
    add_tri(-5 * UNIT, UNIT / 2, 0, 5 * UNIT, UNIT / 2, 0, 0, 10 * UNIT, 0);
    add_tri(-5 * UNIT, UNIT / 2, 0, 0, 10 * UNIT, 0, 5 * UNIT, UNIT / 2, 0);
    add_tri(0, 10 * UNIT, 0, -5 * UNIT, UNIT / 2, 0, 5 * UNIT, UNIT / 2, 0);
    add_tri(-5 * UNIT, 2 * UNIT, 0, 5 * UNIT, 2 * UNIT, 0, 0, 10 * UNIT, 0);
    add_tri(-5 * UNIT, 2 * UNIT, 0, 0, 10 * UNIT, 0, 5 * UNIT, 2 * UNIT, 0);
    add_tri(0, 10 * UNIT, 0, -5 * UNIT, 2 * UNIT, 0, 5 * UNIT, 2 * UNIT, 0);
    add_tri(3 * UNIT, 3 * UNIT, 0, 10 * UNIT, 3 * UNIT, 0, 3 * UNIT, 10 * UNIT, 0);
    add_tri(10 * UNIT, 3 * UNIT, 0, 3 * UNIT, 3 * UNIT, 0, 3 * UNIT, 10 * UNIT, 0);
    add_tri(10 * UNIT, 3 * UNIT, 0, 3 * UNIT, 10 * UNIT, 0, 3 * UNIT, 3 * UNIT, 0);
    add_tri(3 * UNIT, 3 * UNIT, 0, 6 * UNIT, 6 * UNIT, 0, 9 * UNIT, 9 * UNIT, 0);
    add_tri(-3 * UNIT, 0, 0, 3 * UNIT, 0, 0, 9 * UNIT, 0, 0);
    add_tri(3 * UNIT, 0, 0, 3 * UNIT, 0, 0, 3 * UNIT, 5 * UNIT, 0);
    add_tri(3 * UNIT, 0, 0, 3 * UNIT, 5 * UNIT, 0, 3 * UNIT, 5 * UNIT, 0);
    add_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_tri(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
            32'h8000_0000, 32'h8000_0000, 0);
    drain();

    for (int ph = 1; ph <= 7; ph++) begin
      phase_no = ph;
      rs = $urandom_range(8, 30);
      case (ph)
        1: set_circle(32'd0, 32'd0, 32'd0, 32'd0);
        2: set_circle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        3: set_circle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        default: set_circle($urandom, $urandom, $urandom,
                            {1'($urandom_range(0, 1)), 31'($urandom) >> (31 - rs)});
      endcase
      repeat (225) add_random_tri();
      drain();
    end

    repeat (100) @(posedge clk);
    if (class_q.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", class_q.size());
    end
    $display("covered eight circle settings; relations seen 0..6: %0d %0d %0d %0d %0d %0d %0d",
             rel_seen[0], rel_seen[1], rel_seen[2], rel_seen[3], rel_seen[4],
             rel_seen[5], rel_seen[6]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== triangle_circle_classifier.f =====
+incdir+design
design/tcc_pkg.sv
design/tcc_if.sv
design/tcc_front.sv
design/tcc_classify.sv
design/tcc_div.sv
design/triangle_circle_classifier.sv
design/tcc_checker.sv
sim/tb.sv
